>>> rtl/core/idst_pkg.sv
`timescale 1ns / 1ps

package idst_pkg;

    // Table geometry
    localparam int NUM_SLOTS = 8;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ID_W      = 32;
    localparam int CNT_W     = 4;

    // Request codes
    localparam logic [2:0] REQ_PROBE  = 3'd0;
    localparam logic [2:0] REQ_CLEAR  = 3'd1;
    localparam logic [2:0] REQ_ADD    = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_LIST   = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    // Command from the sequencer to the slot store
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [ID_W-1:0]  wr_data;
        logic [IDX_W-1:0] rd_idx;
        logic [ID_W-1:0]  key;
    } slot_cmd_t;

    // Slot contents and compare flags returned to the sequencer
    typedef struct packed {
        logic [ID_W-1:0] ident;
        logic            match;
        logic            free;
    } slot_stat_t;

endpackage

>>> rtl/core/idst_slot_store.sv
`timescale 1ns / 1ps

module idst_slot_store
    import idst_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  slot_cmd_t  cmd,
    output slot_stat_t stat
);

    logic [ID_W-1:0] slot_reg [NUM_SLOTS];

    // Clear every slot at reset, write one slot per cycle otherwise
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_reg[i] <= '0;
            end
        end else if (cmd.wr_en) begin
            slot_reg[cmd.wr_idx] <= cmd.wr_data;
        end
    end

    // Shared compare unit on the slot under the scan pointer
    always_comb begin
        stat.ident = slot_reg[cmd.rd_idx];
        stat.match = (slot_reg[cmd.rd_idx] == cmd.key);
        stat.free  = (slot_reg[cmd.rd_idx] == '0);
    end

endmodule

>>> rtl/core/id_set_table_with_mask_gate_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// s_        in         s_tvalid / s_tready      tuser: req_type; tdata: ident, probe_mask
// m_        out        m_tvalid / m_tready      tuser: entry_valid; tdata: status, hit,
//                                               entry_ident, entry_count; tlast: last
// cfg_      in         cfg_valid / cfg_ready    cfg_data: enable_mask
//
// A request is accepted in idle, walks the slot table one slot per cycle through a single
// compare unit (a list scan waits while an earlier entry is held up at the output), and then
// posts its result in the finish step; probe, add and remove stop early on a match.
// Reset (aresetn low, synchronous) frees every slot and sets enable_mask to all ones.
// s_tready is high only while the sequencer is idle; a stalled output holds the scan
// of a list and the finish step, but a new request is taken while a result waits.

module id_set_table_with_mask_gate_core
    import idst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] ident, [63:32] probe_mask
    input  logic [2:0]  s_tuser,   // [2:0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] status, [2] hit, [34:3] entry_ident,
                                   // [38:35] entry_count, [39] zero
    output logic        m_tuser,   // [0] entry_valid
    output logic        m_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    state_t           state_reg,      state_next;
    logic [2:0]       op_reg,         op_next;
    logic [ID_W-1:0]  ident_reg,      ident_next;
    logic             mask_ok_reg,    mask_ok_next;
    logic [IDX_W-1:0] idx_reg,        idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg,   free_idx_next;
    logic             dup_reg,        dup_next;
    logic [1:0]       fin_status_reg, fin_status_next;
    logic             fin_hit_reg,    fin_hit_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]  pend_ident_reg, pend_ident_next;
    logic [CNT_W-1:0] pend_count_reg, pend_count_next;
    logic [31:0]      enable_mask_reg;

    logic             m_valid_reg;
    logic [1:0]       out_status_reg, out_status_next;
    logic             out_hit_reg,    out_hit_next;
    logic             out_evalid_reg, out_evalid_next;
    logic [ID_W-1:0]  out_ident_reg,  out_ident_next;
    logic [CNT_W-1:0] out_count_reg,  out_count_next;
    logic             out_last_reg,   out_last_next;
    logic             out_load;
    logic             out_free;

    slot_cmd_t        cmd;
    slot_stat_t       stat;
    logic             s_accept;

    idst_slot_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_ident_reg, out_hit_reg, out_status_reg};
    assign m_tuser  = out_evalid_reg;
    assign m_tlast  = out_last_reg;

    // Sequencer: accept, walk the slots, then post the final result
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        ident_next      = ident_reg;
        mask_ok_next    = mask_ok_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        dup_next        = dup_reg;
        fin_status_next = fin_status_reg;
        fin_hit_next    = fin_hit_reg;
        pend_valid_next = pend_valid_reg;
        pend_ident_next = pend_ident_reg;
        pend_count_next = pend_count_reg;

        out_load        = 1'b0;
        out_status_next = STAT_OK;
        out_hit_next    = 1'b0;
        out_evalid_next = 1'b0;
        out_ident_next  = '0;
        out_count_next  = '0;
        out_last_next   = 1'b1;

        cmd.wr_en   = 1'b0;
        cmd.wr_idx  = idx_reg;
        cmd.wr_data = '0;
        cmd.rd_idx  = idx_reg;
        cmd.key     = ident_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_next         = s_tuser;
                    ident_next      = s_tdata[31:0];
                    mask_ok_next    = |(enable_mask_reg & s_tdata[63:32]);
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    dup_next        = 1'b0;
                    fin_status_next = STAT_OK;
                    fin_hit_next    = 1'b0;
                    pend_valid_next = 1'b0;
                    pend_count_next = '0;
                    if (s_tuser inside {REQ_PROBE, REQ_CLEAR, REQ_REMOVE, REQ_LIST}) begin
                        state_next = ST_SCAN;
                    end else if (s_tuser == REQ_ADD && s_tdata[31:0] != '0) begin
                        state_next = ST_SCAN;
                    end else begin
                        fin_status_next = STAT_INVALID;
                        state_next      = ST_FINISH;
                    end
                end
            end

            ST_SCAN: begin
                case (op_reg)
                    REQ_PROBE: begin
                        if (stat.match && ident_reg != '0) begin
                            fin_hit_next = mask_ok_reg;
                            state_next   = ST_FINISH;
                        end else if (idx_reg == LAST_IDX) begin
                            state_next = ST_FINISH;
                        end
                        idx_next = idx_reg + 1'b1;
                    end
                    REQ_CLEAR: begin
                        cmd.wr_en = 1'b1;
                        if (idx_reg == LAST_IDX) begin
                            state_next = ST_FINISH;
                        end
                        idx_next = idx_reg + 1'b1;
                    end
                    REQ_ADD: begin
                        if (stat.match) begin
                            dup_next   = 1'b1;
                            state_next = ST_FINISH;
                        end else begin
                            if (stat.free && !free_found_reg) begin
                                free_found_next = 1'b1;
                                free_idx_next   = idx_reg;
                            end
                            if (idx_reg == LAST_IDX) begin
                                state_next = ST_FINISH;
                            end
                        end
                        idx_next = idx_reg + 1'b1;
                    end
                    REQ_REMOVE: begin
                        if (stat.match) begin
                            cmd.wr_en  = 1'b1;
                            state_next = ST_FINISH;
                        end else if (idx_reg == LAST_IDX) begin
                            state_next = ST_FINISH;
                        end
                        idx_next = idx_reg + 1'b1;
                    end
                    REQ_LIST: begin
                        // hold one entry back so the final one can carry last
                        if (!stat.free && pend_valid_reg && !out_free) begin
                            idx_next = idx_reg;
                        end else begin
                            if (!stat.free) begin
                                if (pend_valid_reg) begin
                                    out_load        = 1'b1;
                                    out_evalid_next = 1'b1;
                                    out_ident_next  = pend_ident_reg;
                                    out_count_next  = pend_count_reg;
                                    out_last_next   = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_ident_next = stat.ident;
                                pend_count_next = pend_count_reg + 1'b1;
                            end
                            if (idx_reg == LAST_IDX) begin
                                state_next = ST_FINISH;
                            end
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (op_reg == REQ_LIST) begin
                        out_evalid_next = pend_valid_reg;
                        out_ident_next  = pend_valid_reg ? pend_ident_reg : '0;
                        out_count_next  = pend_valid_reg ? pend_count_reg : '0;
                    end else if (op_reg == REQ_ADD && fin_status_reg == STAT_OK
                                 && !dup_reg) begin
                        if (free_found_reg) begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_idx  = free_idx_reg;
                            cmd.wr_data = ident_reg;
                        end else begin
                            out_status_next = STAT_FULL;
                        end
                    end else begin
                        out_status_next = fin_status_reg;
                        out_hit_next    = fin_hit_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            enable_mask_reg <= '1;
            m_valid_reg     <= 1'b0;
            pend_valid_reg  <= 1'b0;
            free_found_reg  <= 1'b0;
            dup_reg         <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            free_found_reg <= free_found_next;
            dup_reg        <= dup_next;
            if (cfg_valid && cfg_ready) begin
                enable_mask_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold request context and the output transaction payload
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        ident_reg      <= ident_next;
        mask_ok_reg    <= mask_ok_next;
        idx_reg        <= idx_next;
        free_idx_reg   <= free_idx_next;
        fin_status_reg <= fin_status_next;
        fin_hit_reg    <= fin_hit_next;
        pend_ident_reg <= pend_ident_next;
        pend_count_reg <= pend_count_next;
        if (out_load) begin
            out_status_reg <= out_status_next;
            out_hit_reg    <= out_hit_next;
            out_evalid_reg <= out_evalid_next;
            out_ident_reg  <= out_ident_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
    end

    // A new result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded over a pending output transaction");

    // A list entry always carries a stored, nonzero identifier
    a_entry_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[34:3] != '0 && m_tdata[38:35] != '0))
        else $error("list entry without identifier or count");

    // Results other than list entries carry no identifier or count
    a_plain_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[34:3] == '0 && m_tdata[38:35] == '0
                                    && m_tlast))
        else $error("plain result carries list fields");

    // A hit only comes on a successful single-result probe
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == STAT_OK && m_tlast && !m_tuser))
        else $error("hit on a non-probe result");

    // The finish step hands back to idle once the output frees up
    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> (state_reg == ST_IDLE))
        else $error("sequencer stuck after final result");

endmodule
